FILE: hw/rtl/pngut_pkg.sv
`default_nettype none
package pngut_pkg;

  // Item actions on the input channel.
  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_PAL  = 2'd1,
    ACT_TRNS = 2'd2,
    ACT_EOI  = 2'd3
  } action_t;

  // Result kinds on the output channel.
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_FILTER  = 3'd1;
  localparam logic [2:0] ERR_EXCESS  = 3'd2;
  localparam logic [2:0] ERR_PALETTE = 3'd3;
  localparam logic [2:0] ERR_SHORT   = 3'd4;

  // Color modes; codes above RGBA are treated as grey.
  localparam logic [2:0] MODE_GREY  = 3'd0;
  localparam logic [2:0] MODE_RGB   = 3'd1;
  localparam logic [2:0] MODE_PAL   = 3'd2;
  localparam logic [2:0] MODE_GREYA = 3'd3;
  localparam logic [2:0] MODE_RGBA  = 3'd4;

  // Scanline filter types.
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COLOR_MODE  = 3'd0;
  localparam logic [2:0] CFG_IMG_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_IMG_HEIGHT  = 3'd2;
  localparam logic [2:0] CFG_DECIM_STEP  = 3'd3;
  localparam logic [2:0] CFG_THUMB_WIDTH = 3'd4;
  localparam logic [2:0] CFG_PAL_ENTRIES = 3'd5;
  localparam logic [2:0] CFG_TRNS_ENTRIES = 3'd6;

  // Background color that alpha is flattened onto.
  localparam logic [7:0] BG_RED   = 8'd10;
  localparam logic [7:0] BG_GREEN = 8'd8;
  localparam logic [7:0] BG_BLUE  = 8'd6;

  // Byte position counter width.
  localparam int unsigned BPOS_W = 16;

  // Control flags that travel with an item from the input stage.
  typedef struct packed {
    logic       filter_pos;
    logic       excess;
    logic       mismatch;
    logic       up_zero;
    logic       in_range;
    logic [1:0] chan_idx;
    logic       kept;
    logic       last;
    logic [9:0] kept_col;
    logic [9:0] kept_row;
  } s1_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pngut_ram.sv
`default_nettype none
module pngut_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/png_unfilter_thumbnail_core.sv
// PNG scanline unfilter with a decimated RGB565 thumbnail output.
// Input channel (in_valid / in_stall): one item per transfer, either an inflated
// stream byte, a palette or transparency table write, or an end-of-image mark.
// Output channel (out_valid / out_stall): thumbnail pixels, an image-complete
// mark, or an error code; each input item yields at most one result.
// Configuration (cfg_valid / cfg_ready): register index and data, always ready;
// write registers only while the block is idle.
// Throughput is one item per cycle while the receiver does not stall. The result
// reaches the output register through the input stage register, the unfilter with
// the palette read, the flatten multiply, then the divide by 255 and RGB565 pack.
// The unfilter step, one 8-bit add after the chosen Sub, Up, Average or Paeth
// predictor, closes the loop that carries the left neighbor from one byte to the next.
// All stages advance together; when the output register holds a result and the
// receiver stalls, the whole pipeline holds and in_stall is raised.
// Reset clears the counters, delays, sticky error and the stage and output valid
// flags and sets the first-row flag. The line store, palette and alpha tables are not
// cleared and must be written before they are read.
`default_nettype none
module png_unfilter_thumbnail_core #(
  parameter int unsigned MAX_ROW_BYTES  = 32768,
  parameter int unsigned MAX_DIMENSION  = 8192,
  parameter int unsigned PALETTE_DEPTH  = 256,
  parameter int unsigned MAX_THUMB_EDGE = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [7:0]  in_data_byte,
  input  wire  [7:0]  in_table_index,
  input  wire  [7:0]  in_red,
  input  wire  [7:0]  in_green,
  input  wire  [7:0]  in_blue,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_pixel,
  output logic [9:0]  out_thumb_x,
  output logic [9:0]  out_thumb_y,
  output logic [2:0]  out_error_code,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [13:0] cfg_data
);

  localparam int unsigned LS_AW  = $clog2(MAX_ROW_BYTES);
  localparam int unsigned PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned RC_W   = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned KC_W   = $clog2(MAX_THUMB_EDGE + 1);
  localparam int unsigned CW     = 18;
  localparam int unsigned BW     = pngut_pkg::BPOS_W;

  // Configuration registers.
  logic [2:0]  color_mode_r;
  logic [13:0] image_width_r;
  logic [13:0] image_height_r;
  logic [13:0] decim_step_r;
  logic [10:0] thumb_width_r;
  logic [8:0]  pal_entries_r;
  logic [8:0]  trns_entries_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= pngut_pkg::MODE_GREY;
      image_width_r  <= 14'd1;
      image_height_r <= 14'd1;
      decim_step_r   <= 14'd1;
      thumb_width_r  <= 11'd1;
      pal_entries_r  <= 9'd0;
      trns_entries_r <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pngut_pkg::CFG_COLOR_MODE:   color_mode_r   <= cfg_data[2:0];
        pngut_pkg::CFG_IMG_WIDTH:    image_width_r  <= cfg_data;
        pngut_pkg::CFG_IMG_HEIGHT:   image_height_r <= cfg_data;
        pngut_pkg::CFG_DECIM_STEP:   decim_step_r   <= cfg_data;
        pngut_pkg::CFG_THUMB_WIDTH:  thumb_width_r  <= cfg_data[10:0];
        pngut_pkg::CFG_PAL_ENTRIES:  pal_entries_r  <= cfg_data[8:0];
        pngut_pkg::CFG_TRNS_ENTRIES: trns_entries_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Derived configuration: channel count, effective step and row stride.
  logic [2:0]  ch;
  logic [13:0] step_eff;
  logic [BW-1:0] stride;

  always_comb begin
    case (color_mode_r)
      pngut_pkg::MODE_RGB:   ch = 3'd3;
      pngut_pkg::MODE_GREYA: ch = 3'd2;
      pngut_pkg::MODE_RGBA:  ch = 3'd4;
      default:               ch = 3'd1;
    endcase
    step_eff = (decim_step_r == 14'd0) ? 14'd1 : decim_step_r;
    case (ch)
      3'd2:    stride = BW'({image_width_r, 1'b0});
      3'd3:    stride = BW'({image_width_r, 1'b0}) + BW'(image_width_r);
      3'd4:    stride = BW'({image_width_r, 2'b00});
      default: stride = BW'(image_width_r);
    endcase
  end

  // Pipeline enable: everything holds while a result waits on a stalled receiver.
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic acc;
  assign acc = in_valid && en;

  // ---------------------------------------------------------------------------
  // Input stage: position counters, decimation phases and line store read.
  // ---------------------------------------------------------------------------
  logic            first_row_r, first_row_nxt;
  logic [RC_W-1:0] row_count_r, row_count_nxt;
  logic [BW-1:0]   byte_pos_r, byte_pos_nxt;
  logic [1:0]      chan_idx_r, chan_idx_nxt;
  logic [13:0]     row_phase_r, row_phase_nxt;
  logic [13:0]     col_phase_r, col_phase_nxt;
  logic [KC_W-1:0] kept_col_r, kept_col_nxt;
  logic [KC_W-1:0] kept_row_r, kept_row_nxt;

  logic [BW-1:0]   pos_i;
  logic            s0_excess, s0_last, s0_kept;
  pngut_pkg::s1_ctrl_t s0_ctrl;

  always_comb begin
    pos_i     = byte_pos_r - BW'(1);
    s0_excess = CW'(row_count_r) >= CW'(image_height_r);
    s0_last   = (3'({1'b0, chan_idx_r}) + 3'd1) >= ch;
    s0_kept   = (row_phase_r == 14'd0) && (CW'(kept_row_r) < CW'(MAX_THUMB_EDGE)) &&
                (col_phase_r == 14'd0) && (CW'(kept_col_r) < CW'(thumb_width_r)) &&
                (CW'(kept_col_r) < CW'(MAX_THUMB_EDGE));

    s0_ctrl.filter_pos = (byte_pos_r == BW'(0));
    s0_ctrl.excess     = s0_excess;
    s0_ctrl.mismatch   = (CW'(row_count_r) != CW'(image_height_r)) ||
                         (byte_pos_r != BW'(0));
    s0_ctrl.up_zero    = first_row_r || (CW'(pos_i) >= CW'(MAX_ROW_BYTES));
    s0_ctrl.in_range   = CW'(pos_i) < CW'(MAX_ROW_BYTES);
    s0_ctrl.chan_idx   = chan_idx_r;
    s0_ctrl.kept       = s0_kept;
    s0_ctrl.last       = s0_last;
    s0_ctrl.kept_col   = 10'(kept_col_r);
    s0_ctrl.kept_row   = 10'(kept_row_r);

    first_row_nxt = first_row_r;
    row_count_nxt = row_count_r;
    byte_pos_nxt  = byte_pos_r;
    chan_idx_nxt  = chan_idx_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    kept_col_nxt  = kept_col_r;
    kept_row_nxt  = kept_row_r;

    if (in_action == pngut_pkg::ACT_EOI) begin
      first_row_nxt = 1'b1;
      row_count_nxt = '0;
      byte_pos_nxt  = '0;
      chan_idx_nxt  = '0;
      row_phase_nxt = '0;
      col_phase_nxt = '0;
      kept_col_nxt  = '0;
      kept_row_nxt  = '0;
    end else if (in_action == pngut_pkg::ACT_DATA && !s0_excess) begin
      if (byte_pos_r == BW'(0)) begin
        // Filter type byte opens a row.
        byte_pos_nxt  = BW'(1);
        chan_idx_nxt  = '0;
        col_phase_nxt = '0;
        kept_col_nxt  = '0;
      end else begin
        if (s0_last) begin
          chan_idx_nxt = '0;
          if (col_phase_r == 14'd0 && CW'(kept_col_r) < CW'(MAX_THUMB_EDGE)) begin
            kept_col_nxt = kept_col_r + KC_W'(1);
          end
          col_phase_nxt = (CW'(col_phase_r) + CW'(1) >= CW'(step_eff)) ?
                          14'd0 : col_phase_r + 14'd1;
        end else begin
          chan_idx_nxt = chan_idx_r + 2'd1;
        end
        byte_pos_nxt = byte_pos_r + BW'(1);
        // Row complete after the last filtered byte.
        if (CW'(byte_pos_r) >= CW'(stride)) begin
          row_count_nxt = row_count_r + RC_W'(1);
          byte_pos_nxt  = '0;
          first_row_nxt = 1'b0;
          if (row_phase_r == 14'd0 && CW'(kept_row_r) < CW'(MAX_THUMB_EDGE)) begin
            kept_row_nxt = kept_row_r + KC_W'(1);
          end
          row_phase_nxt = (CW'(row_phase_r) + CW'(1) >= CW'(step_eff)) ?
                          14'd0 : row_phase_r + 14'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= 1'b1;
      row_count_r <= '0;
      byte_pos_r  <= '0;
      chan_idx_r  <= '0;
      row_phase_r <= '0;
      col_phase_r <= '0;
      kept_col_r  <= '0;
      kept_row_r  <= '0;
    end else if (acc) begin
      first_row_r <= first_row_nxt;
      row_count_r <= row_count_nxt;
      byte_pos_r  <= byte_pos_nxt;
      chan_idx_r  <= chan_idx_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      kept_col_r  <= kept_col_nxt;
      kept_row_r  <= kept_row_nxt;
    end
  end

  // Input stage register.
  logic                s1_valid_r;
  pngut_pkg::action_t  s1_action_r;
  logic [7:0]          s1_byte_r, s1_tix_r, s1_red_r, s1_green_r, s1_blue_r;
  logic [LS_AW-1:0]    s1_addr_r;
  pngut_pkg::s1_ctrl_t s1_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_action_r <= pngut_pkg::action_t'(in_action);
      s1_byte_r   <= in_data_byte;
      s1_tix_r    <= in_table_index;
      s1_red_r    <= in_red;
      s1_green_r  <= in_green;
      s1_blue_r   <= in_blue;
      s1_addr_r   <= pos_i[LS_AW-1:0];
      s1_ctrl_r   <= s0_ctrl;
    end
  end

  // ---------------------------------------------------------------------------
  // Unfilter stage: rebuild the byte, update delays, decide the result.
  // ---------------------------------------------------------------------------
  logic [7:0]  ls_rdata;
  logic        ls_we;
  logic [7:0]  recon;

  pngut_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1_addr_r),
    .wdata (recon),
    .re    (en),
    .raddr (pos_i[LS_AW-1:0]),
    .rdata (ls_rdata)
  );

  logic [2:0]  filter_kind_r, filter_kind_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] upl_r, upl_nxt;
  logic [31:0] pixch_r, pixch_nxt;
  logic [2:0]  sticky_r, sticky_nxt;

  logic [7:0]  nb_a, nb_up, nb_ul, pred;
  logic [31:0] pix_full;
  logic signed [10:0] d_bc, d_ac, d_abc;
  logic [10:0] pa, pb, pc;

  logic        res_valid, res_pixel;
  logic [1:0]  res_kind;
  logic [2:0]  res_code;
  logic        pal_we, trns_we, tix_ok;
  logic        pal_err, trns_hit;
  logic        s1_go;

  assign s1_go  = en && s1_valid_r;
  assign tix_ok = {1'b0, s1_tix_r} < 9'(PALETTE_DEPTH);

  // Neighbor bytes and predictor.
  always_comb begin
    case (ch)
      3'd2:    begin nb_a = left_r[15:8];  nb_ul = upl_r[15:8];  end
      3'd3:    begin nb_a = left_r[23:16]; nb_ul = upl_r[23:16]; end
      3'd4:    begin nb_a = left_r[31:24]; nb_ul = upl_r[31:24]; end
      default: begin nb_a = left_r[7:0];   nb_ul = upl_r[7:0];   end
    endcase
    nb_up = s1_ctrl_r.up_zero ? 8'd0 : ls_rdata;

    // Paeth distances: |b-c|, |a-c| and |a+b-2c|.
    d_bc  = $signed({3'b000, nb_up}) - $signed({3'b000, nb_ul});
    d_ac  = $signed({3'b000, nb_a}) - $signed({3'b000, nb_ul});
    d_abc = d_bc + d_ac;
    pa = (d_bc < 0) ? 11'(-d_bc) : 11'(d_bc);
    pb = (d_ac < 0) ? 11'(-d_ac) : 11'(d_ac);
    pc = (d_abc < 0) ? 11'(-d_abc) : 11'(d_abc);

    case (filter_kind_r)
      pngut_pkg::FILT_SUB:   pred = nb_a;
      pngut_pkg::FILT_UP:    pred = nb_up;
      pngut_pkg::FILT_AVG:   pred = 8'((9'(nb_a) + 9'(nb_up)) >> 1);
      pngut_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = nb_a;
        end else if (pb <= pc) begin
          pred = nb_up;
        end else begin
          pred = nb_ul;
        end
      end
      default:               pred = 8'd0;
    endcase
    recon = s1_byte_r + pred;

    // Collect the kept pixel's channels.
    pix_full = pixch_r;
    if (s1_ctrl_r.kept) begin
      case (s1_ctrl_r.chan_idx)
        2'd1:    pix_full[15:8]  = recon;
        2'd2:    pix_full[23:16] = recon;
        2'd3:    pix_full[31:24] = recon;
        default: pix_full[7:0]   = recon;
      endcase
    end
    pal_err  = ({1'b0, pix_full[7:0]} >= pal_entries_r) ||
               ({1'b0, pix_full[7:0]} >= 9'(PALETTE_DEPTH));
    trns_hit = {1'b0, pix_full[7:0]} < trns_entries_r;
  end

  // Result decision and stage state update.
  always_comb begin
    filter_kind_nxt = filter_kind_r;
    left_nxt        = left_r;
    upl_nxt         = upl_r;
    pixch_nxt       = pixch_r;
    sticky_nxt      = sticky_r;
    res_valid       = 1'b0;
    res_pixel       = 1'b0;
    res_kind        = pngut_pkg::KIND_ERROR;
    res_code        = pngut_pkg::ERR_NONE;
    ls_we           = 1'b0;
    pal_we          = 1'b0;
    trns_we         = 1'b0;

    case (s1_action_r)
      pngut_pkg::ACT_PAL: begin
        pal_we = s1_go && tix_ok;
      end
      pngut_pkg::ACT_TRNS: begin
        trns_we = s1_go && tix_ok;
      end
      pngut_pkg::ACT_EOI: begin
        res_valid = 1'b1;
        if (sticky_r != pngut_pkg::ERR_NONE) begin
          res_code = sticky_r;
        end else if (s1_ctrl_r.mismatch) begin
          res_code = pngut_pkg::ERR_SHORT;
        end else begin
          res_kind = pngut_pkg::KIND_DONE;
        end
        sticky_nxt      = pngut_pkg::ERR_NONE;
        filter_kind_nxt = pngut_pkg::FILT_NONE;
        left_nxt        = '0;
        upl_nxt         = '0;
        pixch_nxt       = '0;
      end
      default: begin
        if (sticky_r != pngut_pkg::ERR_NONE) begin
          // Bytes after an error are dropped until end of image.
        end else if (s1_ctrl_r.excess) begin
          res_valid  = 1'b1;
          res_code   = pngut_pkg::ERR_EXCESS;
          sticky_nxt = pngut_pkg::ERR_EXCESS;
        end else if (s1_ctrl_r.filter_pos) begin
          if (s1_byte_r > 8'(pngut_pkg::FILT_PAETH)) begin
            res_valid  = 1'b1;
            res_code   = pngut_pkg::ERR_FILTER;
            sticky_nxt = pngut_pkg::ERR_FILTER;
          end else begin
            filter_kind_nxt = s1_byte_r[2:0];
            left_nxt        = '0;
            upl_nxt         = '0;
            pixch_nxt       = '0;
          end
        end else begin
          ls_we     = s1_go && s1_ctrl_r.in_range;
          left_nxt  = {left_r[23:0], recon};
          upl_nxt   = {upl_r[23:0], nb_up};
          pixch_nxt = pix_full;
          if (s1_ctrl_r.last) begin
            pixch_nxt = '0;
            if (s1_ctrl_r.kept) begin
              res_valid = 1'b1;
              if (color_mode_r == pngut_pkg::MODE_PAL && pal_err) begin
                res_code   = pngut_pkg::ERR_PALETTE;
                sticky_nxt = pngut_pkg::ERR_PALETTE;
              end else begin
                res_kind  = pngut_pkg::KIND_PIXEL;
                res_pixel = 1'b1;
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_kind_r <= pngut_pkg::FILT_NONE;
      left_r        <= '0;
      upl_r         <= '0;
      pixch_r       <= '0;
      sticky_r      <= pngut_pkg::ERR_NONE;
    end else if (s1_go) begin
      filter_kind_r <= filter_kind_nxt;
      left_r        <= left_nxt;
      upl_r         <= upl_nxt;
      pixch_r       <= pixch_nxt;
      sticky_r      <= sticky_nxt;
    end
  end

  // Palette and alpha tables, read with the pixel's index.
  logic [23:0] pal_rdata;
  logic [7:0]  alpha_rdata;

  pngut_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (s1_tix_r[PAL_AW-1:0]),
    .wdata ({s1_red_r, s1_green_r, s1_blue_r}),
    .re    (en),
    .raddr (pix_full[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  pngut_ram #(
    .WIDTH (8),
    .DEPTH (PALETTE_DEPTH)
  ) u_alpha (
    .clk   (clk),
    .we    (trns_we),
    .waddr (s1_tix_r[PAL_AW-1:0]),
    .wdata (s1_byte_r),
    .re    (en),
    .raddr (pix_full[PAL_AW-1:0]),
    .rdata (alpha_rdata)
  );

  // ---------------------------------------------------------------------------
  // Color stage: pick channels and form the flatten products.
  // ---------------------------------------------------------------------------
  logic        s2_valid_r;
  logic        s2_pixel_r, s2_trns_r;
  logic [1:0]  s2_kind_r;
  logic [2:0]  s2_code_r;
  logic [2:0]  s2_mode_r;
  logic [31:0] s2_chan_r;
  logic [9:0]  s2_x_r, s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pixel_r <= res_pixel;
      s2_trns_r  <= trns_hit;
      s2_kind_r  <= res_kind;
      s2_code_r  <= res_code;
      s2_mode_r  <= color_mode_r;
      s2_chan_r  <= pix_full;
      s2_x_r     <= s1_ctrl_r.kept_col;
      s2_y_r     <= s1_ctrl_r.kept_row;
    end
  end

  logic [7:0]  cr, cg, cb, cal, inv_al;
  logic [15:0] prod_r, prod_g, prod_b;

  always_comb begin
    cal = 8'd255;
    case (s2_mode_r)
      pngut_pkg::MODE_RGB: begin
        cr = s2_chan_r[7:0]; cg = s2_chan_r[15:8]; cb = s2_chan_r[23:16];
      end
      pngut_pkg::MODE_PAL: begin
        cr = pal_rdata[23:16]; cg = pal_rdata[15:8]; cb = pal_rdata[7:0];
        if (s2_trns_r) begin
          cal = alpha_rdata;
        end
      end
      pngut_pkg::MODE_GREYA: begin
        cr = s2_chan_r[7:0]; cg = s2_chan_r[7:0]; cb = s2_chan_r[7:0];
        cal = s2_chan_r[15:8];
      end
      pngut_pkg::MODE_RGBA: begin
        cr = s2_chan_r[7:0]; cg = s2_chan_r[15:8]; cb = s2_chan_r[23:16];
        cal = s2_chan_r[31:24];
      end
      default: begin
        cr = s2_chan_r[7:0]; cg = s2_chan_r[7:0]; cb = s2_chan_r[7:0];
      end
    endcase
    inv_al = 8'd255 - cal;
    // Opaque pixels come out unchanged from the same rounding formula.
    prod_r = 16'(cr) * 16'(cal) + 16'(pngut_pkg::BG_RED) * 16'(inv_al) + 16'd127;
    prod_g = 16'(cg) * 16'(cal) + 16'(pngut_pkg::BG_GREEN) * 16'(inv_al) + 16'd127;
    prod_b = 16'(cb) * 16'(cal) + 16'(pngut_pkg::BG_BLUE) * 16'(inv_al) + 16'd127;
  end

  // ---------------------------------------------------------------------------
  // Pack stage: divide by 255 and pack to RGB565.
  // ---------------------------------------------------------------------------
  logic        s3_valid_r;
  logic        s3_pixel_r;
  logic [1:0]  s3_kind_r;
  logic [2:0]  s3_code_r;
  logic [15:0] s3_pr_r, s3_pg_r, s3_pb_r;
  logic [9:0]  s3_x_r, s3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pixel_r <= s2_pixel_r;
      s3_kind_r  <= s2_kind_r;
      s3_code_r  <= s2_code_r;
      s3_pr_r    <= prod_r;
      s3_pg_r    <= prod_g;
      s3_pb_r    <= prod_b;
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
    end
  end

  // Exact x / 255 for 16-bit x below 65535: (x + (x >> 8) + 1) >> 8.
  logic [16:0] qr, qg, qb;
  logic [15:0] pix565;

  always_comb begin
    qr = 17'(s3_pr_r) + 17'(s3_pr_r[15:8]) + 17'd1;
    qg = 17'(s3_pg_r) + 17'(s3_pg_r[15:8]) + 17'd1;
    qb = 17'(s3_pb_r) + 17'(s3_pb_r[15:8]) + 17'd1;
    pix565 = {qr[15:11], qg[15:10], qb[15:11]};
  end

  // Output register.
  logic [1:0]  out_kind_r;
  logic [15:0] out_pixel_r;
  logic [9:0]  out_x_r, out_y_r;
  logic [2:0]  out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r  <= s3_kind_r;
      out_code_r  <= s3_code_r;
      out_pixel_r <= s3_pixel_r ? pix565 : 16'd0;
      out_x_r     <= s3_pixel_r ? s3_x_r : 10'd0;
      out_y_r     <= s3_pixel_r ? s3_y_r : 10'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_pixel      = out_pixel_r;
  assign out_thumb_x    = out_x_r;
  assign out_thumb_y    = out_y_r;
  assign out_error_code = out_code_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A pixel result never carries an error code, and an error always carries one.
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_kind_r == pngut_pkg::KIND_ERROR) == (out_code_r != pngut_pkg::ERR_NONE)))
    else $error("result kind and error code disagree");

  // End of image clears the sticky error.
  a_eoi_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_action_r == pngut_pkg::ACT_EOI) |=> (sticky_r == pngut_pkg::ERR_NONE))
    else $error("sticky error survived end of image");

  // While the pipeline holds, the pack and color stages keep their items.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(s3_valid_r) && $stable(s2_valid_r)))
    else $error("pipeline moved during a stall");

  // No pixel is produced once an error is latched.
  a_no_pix_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && sticky_r != pngut_pkg::ERR_NONE) |-> !res_pixel)
    else $error("pixel produced after an error");

  // The channel index stays below the channel count.
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_action == pngut_pkg::ACT_DATA && byte_pos_r != '0) |->
      (3'({1'b0, chan_idx_r}) < ch))
    else $error("channel index out of range");

endmodule
`default_nettype wire

FILE: tb/png_unfilter_thumbnail_core_test.sv
`default_nettype none
module png_unfilter_thumbnail_core_test;
  import pngut_pkg::*;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel;
    logic [9:0]  tx;
    logic [9:0]  ty;
    logic [2:0]  code;
  } result_t;

  // Scoreboard: holds the predicted results and counts mismatches and surplus results.
  class thumb_scoreboard;
    result_t pending[$];
    int unsigned mismatches;
    int unsigned surplus;

    function void note_input(input result_t r, input bit has);
      if (has) pending.push_back(r);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (pending.size() == 0) begin
        surplus++;
        if (mismatches + surplus <= 10)
          $display("unexpected result kind=%0d pixel=%h x=%0d y=%0d code=%0d",
                   got.kind, got.pixel, got.tx, got.ty, got.code);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches + surplus <= 10)
          $display("mismatch: expected kind=%0d pixel=%h x=%0d y=%0d code=%0d, got kind=%0d pixel=%h x=%0d y=%0d code=%0d",
                   want.kind, want.pixel, want.tx, want.ty, want.code,
                   got.kind, got.pixel, got.tx, got.ty, got.code);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_DATA;
  logic [7:0] in_data_byte = '0, in_table_index = '0, in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [15:0] out_pixel;
  logic [9:0] out_thumb_x, out_thumb_y;
  logic [2:0] out_error_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  png_unfilter_thumbnail_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and configuration copies.
  logic [2:0]  m_mode;
  logic [13:0] m_width, m_height, m_step;
  logic [10:0] m_twidth;
  logic [8:0]  m_pal_n, m_trns_n;
  logic [7:0]  rows_above[int];
  logic [23:0] pal_tab[256];
  logic [7:0]  alpha_tab[256];
  bit          top_row;
  int unsigned rows_done, bpos, filt, left_d, uleft_d, chans_acc;
  int unsigned rph, cph, err_held, cidx, kcol, krow;

  thumb_scoreboard sb = new();
  int unsigned idle_in, idle_out;
  bit hold_off;
  longint unsigned cycles;

  function automatic int unsigned chan_count();
    case (m_mode)
      MODE_RGB:   return 3;
      MODE_GREYA: return 2;
      MODE_RGBA:  return 4;
      default:    return 1;
    endcase
  endfunction

  function automatic int unsigned paeth(int unsigned a, int unsigned b, int unsigned c);
    int p, da, db, dc;
    p = int'(a) + int'(b) - int'(c);
    da = p - int'(a); db = p - int'(b); dc = p - int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : c;
  endfunction

  function automatic int unsigned blend(int unsigned v, int unsigned al, int unsigned bg);
    if (al == 255) return v;
    return (v * al + bg * (255 - al) + 127) / 255;
  endfunction

  function automatic void restart_image();
    top_row = 1; rows_done = 0; bpos = 0; filt = 0; left_d = 0; uleft_d = 0;
    chans_acc = 0; rph = 0; cph = 0; err_held = 0; cidx = 0; kcol = 0; krow = 0;
  endfunction

  function automatic result_t make_res(logic [1:0] k, int unsigned pix, int unsigned x,
                                       int unsigned y, logic [2:0] c);
    result_t r;
    r.kind = k; r.pixel = pix[15:0]; r.tx = x[9:0]; r.ty = y[9:0]; r.code = c;
    return r;
  endfunction

  // Predicts the result of one accepted item; returns 1 if there is one.
  function automatic bit predict_item(input logic [1:0] act, input logic [7:0] b,
                                      input logic [7:0] ix, input logic [7:0] r8,
                                      input logic [7:0] g8, input logic [7:0] b8,
                                      output result_t res);
    int unsigned ch, stp, stride, i, a, up, ul, v, lim, c0, c1, c2, c3, rr, gg, bb, al;
    bit kept, has;
    has = 0;
    if (act == ACT_PAL) begin
      pal_tab[ix] = {r8, g8, b8};
      return 0;
    end
    if (act == ACT_TRNS) begin
      alpha_tab[ix] = b;
      return 0;
    end
    if (act == ACT_EOI) begin
      if (err_held != 0) res = make_res(KIND_ERROR, 0, 0, 0, err_held[2:0]);
      else if (rows_done != m_height || bpos != 0) res = make_res(KIND_ERROR, 0, 0, 0, ERR_SHORT);
      else res = make_res(KIND_DONE, 0, 0, 0, ERR_NONE);
      restart_image();
      return 1;
    end
    if (err_held != 0) return 0;
    if (rows_done >= m_height) begin
      err_held = ERR_EXCESS;
      res = make_res(KIND_ERROR, 0, 0, 0, ERR_EXCESS);
      return 1;
    end
    if (bpos == 0) begin
      if (b > 4) begin
        err_held = ERR_FILTER;
        res = make_res(KIND_ERROR, 0, 0, 0, ERR_FILTER);
        return 1;
      end
      filt = b; bpos = 1; left_d = 0; uleft_d = 0; chans_acc = 0;
      cidx = 0; cph = 0; kcol = 0;
      return 0;
    end
    ch = chan_count();
    stp = (m_step == 0) ? 1 : m_step;
    stride = m_width * ch;
    i = bpos - 1;
    a = (left_d >> (8 * (ch - 1))) & 8'hff;
    ul = (uleft_d >> (8 * (ch - 1))) & 8'hff;
    up = (!top_row && i < 32768 && rows_above.exists(i)) ? rows_above[i] : 0;
    case (filt)
      FILT_SUB:   v = b + a;
      FILT_UP:    v = b + up;
      FILT_AVG:   v = b + ((a + up) >> 1);
      FILT_PAETH: v = b + paeth(a, up, ul);
      default:    v = b;
    endcase
    v &= 8'hff;
    if (i < 32768) rows_above[i] = v[7:0];
    left_d = (left_d << 8) | v;
    uleft_d = (uleft_d << 8) | up;
    lim = (m_twidth < 1024) ? m_twidth : 1024;
    kept = rph == 0 && krow < 1024 && cph == 0 && kcol < lim;
    if (kept) chans_acc |= v << (8 * cidx);
    if (cidx + 1 >= ch) begin
      if (kept) begin
        c0 = chans_acc & 8'hff; c1 = (chans_acc >> 8) & 8'hff;
        c2 = (chans_acc >> 16) & 8'hff; c3 = (chans_acc >> 24) & 8'hff;
        al = 255;
        case (m_mode)
          MODE_RGB: begin rr = c0; gg = c1; bb = c2; end
          MODE_PAL: begin
            if (c0 >= m_pal_n) begin
              err_held = ERR_PALETTE;
              res = make_res(KIND_ERROR, 0, 0, 0, ERR_PALETTE);
              return 1;
            end
            rr = pal_tab[c0][23:16]; gg = pal_tab[c0][15:8]; bb = pal_tab[c0][7:0];
            if (c0 < m_trns_n) al = alpha_tab[c0];
          end
          MODE_GREYA: begin rr = c0; gg = c0; bb = c0; al = c1; end
          MODE_RGBA: begin rr = c0; gg = c1; bb = c2; al = c3; end
          default: begin rr = c0; gg = c0; bb = c0; end
        endcase
        rr = blend(rr, al, BG_RED); gg = blend(gg, al, BG_GREEN); bb = blend(bb, al, BG_BLUE);
        res = make_res(KIND_PIXEL, ((rr & 8'hf8) << 8) | ((gg & 8'hfc) << 3) | (bb >> 3),
                       kcol, krow, ERR_NONE);
        has = 1;
      end
      if (cph == 0) kcol++;
      cph = (cph + 1 >= stp) ? 0 : cph + 1;
      cidx = 0;
      chans_acc = 0;
    end else begin
      cidx++;
    end
    bpos++;
    if (bpos >= stride + 1) begin
      rows_done++; bpos = 0; top_row = 0;
      if (rph == 0) krow++;
      rph = (rph + 1 >= stp) ? 0 : rph + 1;
    end
    return has;
  endfunction

  // Output side: sample at the rising edge, drive stall at the falling edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_kind, out_pixel, out_thumb_x, out_thumb_y, out_error_code});
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < idle_out);
  end

  // Timeout watchdog.
  initial begin
    wait (cycles > 64'd2000000);
    $display("FAIL");
    $finish;
  end

  // Offers one item and waits for its transfer.
  task automatic send_item(input logic [1:0] act, input logic [7:0] b,
                           input logic [7:0] ix = 0, input logic [7:0] r8 = 0,
                           input logic [7:0] g8 = 0, input logic [7:0] b8 = 0);
    result_t res;
    bit has;
    while ($urandom_range(99) < idle_in) @(negedge clk);
    in_valid <= 1'b1; in_action <= act; in_data_byte <= b; in_table_index <= ix;
    in_red <= r8; in_green <= g8; in_blue <= b8;
    do @(posedge clk); while (in_stall);
    has = predict_item(act, b, ix, r8, g8, b8, res);
    sb.note_input(res, has);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Waits until every predicted result has arrived, then lets the pipeline drain.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COLOR_MODE:   m_mode = val[2:0];
      CFG_IMG_WIDTH:    m_width = val;
      CFG_IMG_HEIGHT:   m_height = val;
      CFG_DECIM_STEP:   m_step = val;
      CFG_THUMB_WIDTH:  m_twidth = val[10:0];
      CFG_PAL_ENTRIES:  m_pal_n = val[8:0];
      CFG_TRNS_ENTRIES: m_trns_n = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(input logic [2:0] mode, input int w, input int h, input int stp,
                       input int tw, input int pn, input int tn);
    drain();
    write_reg(CFG_COLOR_MODE, 14'(mode));
    write_reg(CFG_IMG_WIDTH, 14'(w));
    write_reg(CFG_IMG_HEIGHT, 14'(h));
    write_reg(CFG_DECIM_STEP, 14'(stp));
    write_reg(CFG_THUMB_WIDTH, 14'(tw));
    write_reg(CFG_PAL_ENTRIES, 14'(pn));
    write_reg(CFG_TRNS_ENTRIES, 14'(tn));
  endtask

  // Fills the palette and alpha entries that the images can index.
  task automatic load_tables();
    for (int k = 0; k < 64; k++) begin
      send_item(ACT_PAL, 8'd0, 8'(k), 8'($urandom), 8'($urandom), 8'($urandom));
      send_item(ACT_TRNS, (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom), 8'(k));
    end
  endtask

  // Sends one well-formed image of random content; noise adds broken streams.
  task automatic send_image(input int w, input int h, input int noise);
    int unsigned ch, pal_lim;
    logic [7:0] b;
    ch = chan_count();
    pal_lim = (m_pal_n == 0) ? 1 : m_pal_n;
    for (int r = 0; r < h; r++) begin
      b = ($urandom_range(99) < noise) ? 8'($urandom_range(255, 5)) : 8'($urandom_range(4));
      send_item(ACT_DATA, b);
      for (int k = 0; k < w * ch; k++) begin
        b = 8'($urandom);
        if (m_mode == MODE_PAL && $urandom_range(99) >= noise && b >= pal_lim)
          b = 8'($urandom_range(pal_lim - 1));
        if (m_mode == MODE_PAL && filt != FILT_NONE && $urandom_range(99) >= noise) b = 0;
        send_item(ACT_DATA, b);
      end
    end
    if ($urandom_range(99) < noise) send_item(ACT_DATA, 8'($urandom));
    send_item(ACT_EOI, 8'($urandom));
  endtask

  task automatic random_phase(input int unsigned items);
    int w, h;
    logic [2:0] mode;
    repeat (items / 40) begin
      mode = 3'($urandom_range(7));
      w = $urandom_range(6, 1);
      h = $urandom_range(4, 1);
      setup(mode, w, h, $urandom_range(3, 1), $urandom_range(6, 1),
            $urandom_range(64), $urandom_range(256));
      send_image(w, h, 15);
    end
  endtask

  initial begin
    m_mode = 0; m_width = 1; m_height = 1; m_step = 1; m_twidth = 1;
    m_pal_n = 0; m_trns_n = 0;
    restart_image();
    idle_in = 6; idle_out = 84; hold_off = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: four filters, three modes, extremes and the error cases.
    setup(MODE_RGBA, 2, 2, 1, 1024, 256, 256);
    load_tables();
    send_item(ACT_DATA, FILT_PAETH);
    send_item(ACT_DATA, 8'hff); send_item(ACT_DATA, 0); send_item(ACT_DATA, 8'h80);
    send_item(ACT_DATA, 8'hff); send_item(ACT_DATA, 1); send_item(ACT_DATA, 8'hff);
    send_item(ACT_DATA, 0); send_item(ACT_DATA, 0);
    send_item(ACT_DATA, FILT_AVG);
    repeat (8) send_item(ACT_DATA, 8'($urandom));
    send_item(ACT_DATA, 8'h12);
    send_item(ACT_EOI, 0);
    send_item(ACT_DATA, 5);
    send_item(ACT_DATA, 8'hff);
    send_item(ACT_EOI, 0);
    send_item(ACT_EOI, 0);
    setup(MODE_PAL, 3, 1, 0, 0, 2, 1);
    send_item(ACT_DATA, FILT_NONE);
    send_item(ACT_DATA, 0); send_item(ACT_DATA, 1); send_item(ACT_DATA, 8'hff);
    send_item(ACT_EOI, 0);
    setup(MODE_GREY, 8192, 8192, 8192, 1, 0, 0);
    send_item(ACT_DATA, FILT_UP); send_item(ACT_DATA, 8'haa);
    send_item(ACT_EOI, 0);

    // Long hold-off on the receiver while the sender keeps offering items.
    setup(MODE_RGB, 8, 2, 1, 1024, 256, 0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      send_image(8, 2, 0);
    join

    random_phase(170);
    idle_in = 84; idle_out = 6;
    random_phase(170);
    idle_in = 0; idle_out = 0;
    random_phase(170);
    setup(MODE_GREYA, 3, 3, 2, 1, 256, 256);
    send_image(3, 3, 0);

    drain();
    if (sb.mismatches == 0 && sb.surplus == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
